// ===== hdl/spir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spir_pkg
// Shared types for the sphere pair impulse resolve unit: datapath operation
// codes and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package spir_pkg;

    localparam int unsigned InW  = 224;
    localparam int unsigned OutW = 200;
    localparam int unsigned CfgW = 17;

    typedef enum logic [3:0] {
        OP_SQ,
        OP_SQRT,
        OP_NRM,
        OP_VAN,
        OP_E2,
        OP_JNUM,
        OP_JDIV,
        OP_IMP,
        OP_DVA,
        OP_DVB,
        OP_CDIV,
        OP_COR,
        OP_DPA,
        OP_DPB
    } spir_op_t;

    typedef struct packed {
        logic       load_a;
        logic       load_b;
        logic       start;
        spir_op_t   op;
        logic [1:0] ax;
        logic       set_hit;
        logic       out_a;
        logic       out_b;
    } spir_cmd_t;

    typedef struct packed {
        logic done;
        logic geom_ok;
        logic dist_ok;
        logic van_pos;
    } spir_sts_t;

endpackage

// ===== hdl/spir_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spir_mul
// Iterative unsigned 48x48 multiplier, one 48x16 partial product per cycle.
// ----------------------------------------------------------------------------
module spir_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] a,
    input  logic [47:0] b,
    output logic        done,
    output logic [95:0] prod
);

    localparam int unsigned Steps = 3;

    logic [47:0] a_reg;
    logic [47:0] b_reg;
    logic [95:0] acc_reg;
    logic [95:0] acc_next;
    logic [63:0] part;
    logic [1:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    assign part     = 64'(a_reg) * 64'(b_reg[47:32]);
    assign acc_next = {acc_reg[79:0], 16'h0000} + {32'h0, part};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'(Steps - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[31:0], 16'h0000};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== hdl/spir_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spir_div
// Restoring divider, 56-bit dividend by 32-bit divisor, 4 quotient bits/cycle.
// ----------------------------------------------------------------------------
module spir_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [55:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [55:0] quo
);

    localparam int unsigned Steps = 14;

    logic [55:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [55:0] q_next;
    logic [31:0] rem_next;
    logic [32:0] trial;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int k = 0; k < 4; k++)
        begin
            trial  = {rem_next, q_next[55]};
            q_next = {q_next[54:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = 32'(trial - {1'b0, den_reg});
                q_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(Steps - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ===== hdl/spir_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spir_sqrt
// Integer square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module spir_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] v,
    output logic        done,
    output logic [15:0] root
);

    localparam int unsigned Steps = 16;

    logic [31:0] v_reg;
    logic [16:0] rem_reg;
    logic [15:0] res_reg;
    logic [18:0] rem_sh;
    logic [18:0] trial;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    assign rem_sh = {rem_reg, v_reg[31:30]};
    assign trial  = {1'b0, res_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(Steps - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= v;
            rem_reg <= '0;
            res_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg <= {v_reg[29:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg <= 17'(rem_sh - trial);
                res_reg <= {res_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[16:0];
                res_reg <= {res_reg[14:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg;

endmodule

// ===== hdl/spir_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spir_datapath
// Held body, working registers, shared multiply/divide/root units and the
// result register of the pair resolver.
// ----------------------------------------------------------------------------
module spir_datapath
    import spir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  spir_cmd_t          cmd,
    output spir_sts_t          sts,
    input  logic [InW-1:0]     in_data,
    input  logic               cfg_we,
    input  logic [CfgW-1:0]    cfg_data,
    output logic [OutW-1:0]    out_data,
    output logic               out_which,
    output logic               out_last
);

    localparam logic [16:0] RadiusSum = 17'd65536;
    localparam logic [16:0] Slop      = 17'd655;
    localparam logic [13:0] Percent   = 14'd13107;
    localparam logic [18:0] One       = 19'd65536;

    logic signed [31:0] in_pos [3];
    logic signed [31:0] in_vel [3];
    logic [30:0]        in_im;
    logic signed [32:0] d_full [3];
    logic [2:0]         d_small;

    logic signed [31:0] held_pos_reg [3];
    logic signed [31:0] held_vel_reg [3];
    logic [30:0]        held_im_reg;
    logic [CfgW-1:0]    rest_reg;
    logic               hit_reg;

    logic signed [48:0] pa_reg [3];
    logic signed [48:0] pb_reg [3];
    logic signed [48:0] va_reg [3];
    logic signed [48:0] vb_reg [3];
    logic signed [16:0] d_reg  [3];
    logic signed [17:0] n_reg  [3];
    logic [30:0]        ima_reg;
    logic [30:0]        imb_reg;
    logic [31:0]        sum_reg;
    logic               geom_ok_reg;
    logic [34:0]        dist2_reg;
    logic [15:0]        len_reg;
    logic signed [52:0] van_reg;
    logic [17:0]        e2_reg;
    logic [55:0]        jnum_reg;
    logic [46:0]        scal_reg;
    logic               tmp_neg_reg;
    logic [46:0]        tmp_mag_reg;

    logic [OutW-1:0]    out_data_reg;
    logic               out_which_reg;
    logic               out_last_reg;

    logic signed [16:0] d_sel;
    logic [15:0]        d_mag;
    logic signed [17:0] n_sel;
    logic [16:0]        n_mag;
    logic signed [49:0] diff;
    logic [47:0]        diff_mag;
    logic [52:0]        van_mag;
    logic [18:0]        f_w;
    logic [16:0]        pen;
    logic [16:0]        excess;
    logic [30:0]        cnum;
    logic [46:0]        mcap;
    logic signed [48:0] delta;
    logic signed [52:0] vprod;
    logic [46:0]        qcap;

    logic [47:0]        mul_a;
    logic [47:0]        mul_b;
    logic [95:0]        mul_prod;
    logic               mul_done;
    logic               mul_start;
    logic [55:0]        div_num;
    logic [31:0]        div_den;
    logic [55:0]        div_q;
    logic               div_done;
    logic               div_start;
    logic [15:0]        sq_root;
    logic               sq_done;
    logic               sq_start;
    logic               unit_done;

    function automatic logic [31:0] sat32(input logic signed [48:0] x);
        if (x[48:31] == {18{x[48]}})
            return x[31:0];
        else if (x[48])
            return 32'h8000_0000;
        else
            return 32'h7FFF_FFFF;
    endfunction

    function automatic logic [46:0] cap47(input logic [95:0] p);
        return (|p[95:63]) ? {47{1'b1}} : p[62:16];
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_pos[i]  = in_data[32*i +: 32];
            in_vel[i]  = in_data[96 + 32*i +: 32];
            d_full[i]  = {in_pos[i][31], in_pos[i]} - {held_pos_reg[i][31], held_pos_reg[i]};
            d_small[i] = (d_full[i][32:16] == 17'h0)
                      || ((d_full[i][32:16] == 17'h1FFFF) && (d_full[i][15:0] != 16'h0));
        end
        in_im = in_data[222:192];
    end

    assign d_sel    = d_reg[cmd.ax];
    assign d_mag    = d_sel[16] ? 16'(-d_sel) : d_sel[15:0];
    assign n_sel    = n_reg[cmd.ax];
    assign n_mag    = n_sel[17] ? 17'(-n_sel) : n_sel[16:0];
    assign diff     = {vb_reg[cmd.ax][48], vb_reg[cmd.ax]} - {va_reg[cmd.ax][48], va_reg[cmd.ax]};
    assign diff_mag = diff[49] ? 48'(-diff) : diff[47:0];
    assign van_mag  = 53'(-van_reg);
    assign f_w      = One + 19'(e2_reg);
    assign pen      = RadiusSum - 17'(len_reg);
    assign excess   = (pen > Slop) ? (pen - Slop) : 17'd0;
    assign cnum     = 31'(excess) * 31'(Percent);
    assign mcap     = cap47(mul_prod);
    assign delta    = tmp_neg_reg ? -$signed({2'b00, mcap}) : $signed({2'b00, mcap});
    assign vprod    = $signed({1'b0, mul_prod[51:0]});
    assign qcap     = (|div_q[55:47]) ? {47{1'b1}} : div_q[46:0];

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        case (cmd.op)
            OP_SQ:
            begin
                mul_a = 48'(d_mag);
                mul_b = 48'(d_mag);
            end
            OP_VAN:
            begin
                mul_a = diff_mag;
                mul_b = 48'(n_mag);
            end
            OP_E2:
            begin
                mul_a = 48'(rest_reg);
                mul_b = 48'(rest_reg);
            end
            OP_JNUM:
            begin
                mul_a = 48'(f_w);
                mul_b = 48'(van_mag[52:16]);
            end
            OP_IMP, OP_COR:
            begin
                mul_a = 48'(scal_reg);
                mul_b = 48'(n_mag);
            end
            OP_DVA, OP_DPA:
            begin
                mul_a = 48'(tmp_mag_reg);
                mul_b = 48'(ima_reg);
            end
            OP_DVB, OP_DPB:
            begin
                mul_a = 48'(tmp_mag_reg);
                mul_b = 48'(imb_reg);
            end
            OP_NRM:
            begin
                div_num = 56'({d_mag, 16'h0000});
                div_den = 32'(len_reg);
            end
            OP_JDIV:
            begin
                div_num = jnum_reg;
                div_den = sum_reg;
            end
            OP_CDIV:
            begin
                div_num = 56'(cnum);
                div_den = sum_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign sq_start  = cmd.start && (cmd.op == OP_SQRT);
    assign div_start = cmd.start && ((cmd.op == OP_NRM) || (cmd.op == OP_JDIV)
                                     || (cmd.op == OP_CDIV));
    assign mul_start = cmd.start && !sq_start && !div_start;
    assign unit_done = mul_done || div_done || sq_done;

    spir_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    spir_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    spir_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .v     (dist2_reg[31:0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_pos_reg[i] <= '0;
                held_vel_reg[i] <= '0;
            end
            held_im_reg <= '0;
            rest_reg    <= CfgW'(65536);
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                rest_reg <= cfg_data;
            if (cmd.load_a)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    held_pos_reg[i] <= in_pos[i];
                    held_vel_reg[i] <= in_vel[i];
                end
                held_im_reg <= in_im;
            end
            if (cmd.load_b)
                hit_reg <= 1'b0;
            else if (cmd.set_hit)
                hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_b)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= 49'(held_pos_reg[i]);
                va_reg[i] <= 49'(held_vel_reg[i]);
                pb_reg[i] <= 49'(in_pos[i]);
                vb_reg[i] <= 49'(in_vel[i]);
                d_reg[i]  <= d_full[i][16:0];
            end
            ima_reg     <= held_im_reg;
            imb_reg     <= in_im;
            sum_reg     <= 32'(held_im_reg) + 32'(in_im);
            geom_ok_reg <= (&d_small) && ((held_im_reg != '0) || (in_im != '0));
            dist2_reg   <= '0;
            van_reg     <= '0;
        end
        else if (unit_done)
        begin
            case (cmd.op)
                OP_SQ:   dist2_reg <= dist2_reg + mul_prod[34:0];
                OP_SQRT: len_reg <= sq_root;
                OP_NRM:  n_reg[cmd.ax] <= d_sel[16] ? -$signed({1'b0, div_q[16:0]})
                                                    : $signed({1'b0, div_q[16:0]});
                OP_VAN:  van_reg <= (diff[49] ^ n_sel[17]) ? (van_reg - vprod)
                                                           : (van_reg + vprod);
                OP_E2:   e2_reg <= mul_prod[33:16];
                OP_JNUM: jnum_reg <= mul_prod[55:0];
                OP_JDIV, OP_CDIV:
                         scal_reg <= qcap;
                OP_IMP, OP_COR:
                begin
                    tmp_neg_reg <= n_sel[17];
                    tmp_mag_reg <= mcap;
                end
                OP_DVA:  va_reg[cmd.ax] <= va_reg[cmd.ax] - delta;
                OP_DVB:  vb_reg[cmd.ax] <= vb_reg[cmd.ax] + delta;
                OP_DPA:  pa_reg[cmd.ax] <= pa_reg[cmd.ax] - delta;
                OP_DPB:  pb_reg[cmd.ax] <= pb_reg[cmd.ax] + delta;
                default: len_reg <= len_reg;
            endcase
        end

        if (cmd.out_a)
        begin
            out_data_reg  <= {7'h00, hit_reg, sat32(va_reg[2]), sat32(va_reg[1]),
                              sat32(va_reg[0]), sat32(pa_reg[2]), sat32(pa_reg[1]),
                              sat32(pa_reg[0])};
            out_which_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.out_b)
        begin
            out_data_reg  <= {7'h00, hit_reg, sat32(vb_reg[2]), sat32(vb_reg[1]),
                              sat32(vb_reg[0]), sat32(pb_reg[2]), sat32(pb_reg[1]),
                              sat32(pb_reg[0])};
            out_which_reg <= 1'b1;
            out_last_reg  <= 1'b1;
        end
    end

    assign sts.done    = unit_done;
    assign sts.geom_ok = geom_ok_reg;
    assign sts.dist_ok = (dist2_reg != '0) && (dist2_reg[34:32] == 3'b000);
    assign sts.van_pos = !van_reg[52] && (van_reg != '0);

    assign out_data  = out_data_reg;
    assign out_which = out_which_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hdl/spir_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spir_ctrl
// Sequencer of the pair resolver: input handshake, operation sequence over
// the shared units, and the two-transaction result handshake.
// ----------------------------------------------------------------------------
module spir_ctrl
    import spir_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  logic      s_tuser,
    output logic      s_tready,
    input  logic      m_tready,
    output logic      m_tvalid,
    input  spir_sts_t sts,
    output spir_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GEOM,
        S_ISSUE,
        S_WAIT,
        S_ADV,
        S_OUT_A,
        S_OUT_B
    } state_t;

    state_t     state_reg, state_next;
    spir_op_t   op_reg, op_next;
    logic [1:0] ax_reg, ax_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;
    logic       ax_last;

    assign out_free = !m_tvalid_reg || m_tready;
    assign ax_last  = (ax_reg == 2'd2);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        ax_next       = ax_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        cmd           = '0;
        cmd.op        = op_reg;
        cmd.ax        = ax_reg;
        s_tready      = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        cmd.load_b = 1'b1;
                        state_next = S_GEOM;
                    end
                    else
                    begin
                        cmd.load_a = 1'b1;
                    end
                end
            end
            S_GEOM:
            begin
                if (sts.geom_ok)
                begin
                    op_next    = OP_SQ;
                    ax_next    = 2'd0;
                    state_next = S_ISSUE;
                end
                else
                begin
                    state_next = S_OUT_A;
                end
            end
            S_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.done)
                    state_next = S_ADV;
            end
            S_ADV:
            begin
                state_next = S_ISSUE;
                case (op_reg)
                    OP_SQ:
                    begin
                        if (!ax_last)
                            ax_next = ax_reg + 2'd1;
                        else if (sts.dist_ok)
                        begin
                            cmd.set_hit = 1'b1;
                            op_next     = OP_SQRT;
                        end
                        else
                            state_next = S_OUT_A;
                    end
                    OP_SQRT:
                    begin
                        op_next = OP_NRM;
                        ax_next = 2'd0;
                    end
                    OP_NRM:
                    begin
                        if (!ax_last)
                            ax_next = ax_reg + 2'd1;
                        else
                        begin
                            op_next = OP_VAN;
                            ax_next = 2'd0;
                        end
                    end
                    OP_VAN:
                    begin
                        if (!ax_last)
                            ax_next = ax_reg + 2'd1;
                        else if (sts.van_pos)
                            state_next = S_OUT_A;
                        else
                            op_next = OP_E2;
                    end
                    OP_E2:   op_next = OP_JNUM;
                    OP_JNUM: op_next = OP_JDIV;
                    OP_JDIV:
                    begin
                        op_next = OP_IMP;
                        ax_next = 2'd0;
                    end
                    OP_IMP:  op_next = OP_DVA;
                    OP_DVA:  op_next = OP_DVB;
                    OP_DVB:
                    begin
                        if (!ax_last)
                        begin
                            op_next = OP_IMP;
                            ax_next = ax_reg + 2'd1;
                        end
                        else
                            op_next = OP_CDIV;
                    end
                    OP_CDIV:
                    begin
                        op_next = OP_COR;
                        ax_next = 2'd0;
                    end
                    OP_COR:  op_next = OP_DPA;
                    OP_DPA:  op_next = OP_DPB;
                    OP_DPB:
                    begin
                        if (!ax_last)
                        begin
                            op_next = OP_COR;
                            ax_next = ax_reg + 2'd1;
                        end
                        else
                            state_next = S_OUT_A;
                    end
                    default: state_next = S_OUT_A;
                endcase
            end
            S_OUT_A:
            begin
                if (out_free)
                begin
                    cmd.out_a     = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_OUT_B;
                end
            end
            S_OUT_B:
            begin
                if (out_free)
                begin
                    cmd.out_b     = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_SQ;
            ax_reg       <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            ax_reg       <= ax_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> state_reg == S_WAIT)
        else $error("unit completion outside of wait state");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_OUT_A || $past(state_reg) == S_OUT_B))
        else $error("result raised outside output states");

    a_hit_needs_geom: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_hit |-> (sts.geom_ok && sts.dist_ok))
        else $error("contact flagged without passing overlap test");

endmodule

// ===== hdl/sphere_pair_impulse_resolve_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_pair_impulse_resolve_unit
// Sphere pair contact resolver: impulse and positional correction in Q16.16.
// ----------------------------------------------------------------------------
// Bodies arrive on the s_ channel, one per transaction; s_tuser = 0 marks the
// first body of a pair (held, no result), s_tuser = 1 the second body, which
// starts resolution. Each pair yields two m_ transactions: body A (m_tuser = 0)
// then body B (m_tuser = 1, m_tlast = 1). The cfg_ port writes restitution and
// is always ready; write it only while the block is idle.
// A second body holds the input while the pair is resolved; resolution stops
// early when the overlap or mass test fails, when the distance test fails
// and when the spheres separate. For a full contact, one shared multiplier
// runs 26 products, one shared divider runs the three normal components and
// two scale quotients, and a root unit gives the center distance; each
// operation passes through issue, completion and advance.
// Results sit in an output register; the next body is taken as soon as the
// second result is loaded, even while m_tready holds it. A stalled receiver
// blocks the sequencer only when a new result has to be loaded.
// Reset clears the held body to zeros and sets restitution to 1.0.
// ----------------------------------------------------------------------------
module sphere_pair_impulse_resolve_unit
    import spir_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, inv_mass, zero pad
    input  logic [InW-1:0]  s_tdata,
    // is_second
    input  logic            s_tuser,
    output logic            m_tvalid,
    input  logic            m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    // collided, zero pad
    output logic [OutW-1:0] m_tdata,
    // which_body
    output logic            m_tuser,
    output logic            m_tlast,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [CfgW-1:0] cfg_data
);

    spir_cmd_t cmd;
    spir_sts_t sts;

    assign cfg_ready = 1'b1;

    spir_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    spir_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata),
        .out_which (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sphere pair impulse resolve unit. Bodies are
// streamed mostly in pairs, with stray single bodies mixed in; a built-in
// fixed-point contact predictor computes the expected body A and body B
// transactions, which are compared field by field.
module tb;
    import spir_pkg::*;

    localparam longint Cap = 64'sh7FFF_FFFF_FFFF;

    typedef struct {
        logic        which;
        logic [31:0] p [3];
        logic [31:0] v [3];
        logic        hit;
    } body_res_t;

    function automatic longint sat_cap(longint m, bit neg);
        if (m > Cap) m = Cap;
        return neg ? -m : m;
    endfunction

    function automatic longint abs64(longint a);
        return a < 0 ? -a : a;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint ma = abs64(a);
        longint mb = abs64(b);
        longint r;
        if (mb != 0 && ma > (Cap <<< 16) / mb) r = Cap;
        else r = (ma * mb) >>> 16;
        return sat_cap(r, (a < 0) != (b < 0));
    endfunction

    function automatic longint qdiv(longint num, longint den);
        return sat_cap(abs64(num) / den, num < 0);
    endfunction

    function automatic longint isqrt(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    class contact_scoreboard;
        longint        held_p [3];
        longint        held_v [3];
        longint        held_im;
        longint        rest;
        body_res_t     pending [$];
        int            errors;

        function new();
            rest = 65536;
            errors = 0;
            foreach (held_p[i])
            begin
                held_p[i] = 0;
                held_v[i] = 0;
            end
            held_im = 0;
        endfunction

        function void note_body(logic [InW-1:0] d, logic second);
            longint pa[3], va[3], pb[3], vb[3], dd[3], nn[3];
            longint imb, sum, len, van, f, j, ex, c, t;
            longint unsigned dist2;
            bit hit;
            body_res_t ra, rb;
            dist2 = 0;
            hit = 1;
            if (!second)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    held_p[i] = longint'($signed(d[32*i +: 32]));
                    held_v[i] = longint'($signed(d[32*(i+3) +: 32]));
                end
                held_im = longint'({1'b0, d[192 +: 31]});
                return;
            end
            for (int i = 0; i < 3; i++)
            begin
                pa[i] = held_p[i];
                va[i] = held_v[i];
                pb[i] = longint'($signed(d[32*i +: 32]));
                vb[i] = longint'($signed(d[32*(i+3) +: 32]));
                dd[i] = pb[i] - pa[i];
                if (abs64(dd[i]) >= 65536) hit = 0;
            end
            imb = longint'({1'b0, d[192 +: 31]});
            sum = held_im + imb;
            if (hit)
            begin
                for (int i = 0; i < 3; i++) dist2 += longint'(dd[i] * dd[i]);
                if (dist2 == 0 || dist2 >= 64'd1 << 32 || sum == 0) hit = 0;
            end
            if (hit)
            begin
                len = isqrt(dist2);
                van = 0;
                for (int i = 0; i < 3; i++) nn[i] = (dd[i] * 65536) / len;
                for (int i = 0; i < 3; i++) van += (vb[i] - va[i]) * nn[i];
                if (van <= 0)
                begin
                    f = 65536 + ((rest * rest) >>> 16);
                    j = qdiv(-(f * (van / 65536)), sum);
                    for (int i = 0; i < 3; i++)
                    begin
                        t = qmul(j, nn[i]);
                        va[i] -= qmul(t, held_im);
                        vb[i] += qmul(t, imb);
                    end
                    ex = 65536 - len - 655;
                    if (ex < 0) ex = 0;
                    c = qdiv(13107 * ex, sum);
                    for (int i = 0; i < 3; i++)
                    begin
                        t = qmul(c, nn[i]);
                        pa[i] -= qmul(t, held_im);
                        pb[i] += qmul(t, imb);
                    end
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                ra.p[i] = sat32(pa[i]);
                ra.v[i] = sat32(va[i]);
                rb.p[i] = sat32(pb[i]);
                rb.v[i] = sat32(vb[i]);
            end
            ra.which = 0;
            rb.which = 1;
            ra.hit = hit;
            rb.hit = hit;
            pending = {pending, ra, rb};
        endfunction

        function void check_result(logic [OutW-1:0] d, logic user, logic lst);
            body_res_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result tdata=%h", $time, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (user !== e.which || lst !== e.which || d[192] !== e.hit)
            begin
                $display("%0t: flags exp body=%0d hit=%0d act body=%0d last=%0d hit=%0d",
                         $time, e.which, e.hit, user, lst, d[192]);
                errors++;
            end
            for (int i = 0; i < 3; i++)
            begin
                if (d[32*i +: 32] !== e.p[i])
                begin
                    $display("%0t: pos[%0d] exp %h act %h", $time, i, e.p[i],
                             d[32*i +: 32]);
                    errors++;
                end
                if (d[32*(i+3) +: 32] !== e.v[i])
                begin
                    $display("%0t: vel[%0d] exp %h act %h", $time, i, e.v[i],
                             d[32*(i+3) +: 32]);
                    errors++;
                end
            end
            if (d[OutW-1:193] !== '0)
            begin
                $display("%0t: pad exp 0 act %h", $time, d[OutW-1:193]);
                errors++;
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [InW-1:0]  s_tdata;
    logic            s_tuser;
    logic            m_tvalid;
    logic            m_tready;
    logic [OutW-1:0] m_tdata;
    logic            m_tuser;
    logic            m_tlast;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [CfgW-1:0] cfg_data;

    contact_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;

    sphere_pair_impulse_resolve_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("sphere_pair_impulse_resolve_unit verification failed");
        $finish;
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // s_tvalid stays high after a transaction so that the next one can follow
    // back to back; drain() drops it
    task automatic send_body(logic [31:0] p [3], logic [31:0] v [3], logic [30:0] im,
                             logic second);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, im, v[2], v[1], v[0], p[2], p[1], p[0]};
        s_tuser <= second;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_body(s_tdata, s_tuser);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(3))
            0: return 32'h8000_0000 ^ ($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_pair(bit near, bit raw);
        logic [31:0] pa [3], va [3], pb [3], vb [3];
        logic [30:0] ima, imb;
        for (int i = 0; i < 3; i++)
        begin
            pa[i] = raw ? rnd_word() : 32'($signed($urandom_range(400000)) - 200000);
            pb[i] = near ? pa[i] + 32'($signed($urandom_range(90000)) - 45000) : rnd_word();
            va[i] = raw ? rnd_word() : 32'($signed($urandom_range(600000)) - 300000);
            vb[i] = raw ? rnd_word() : 32'($signed($urandom_range(600000)) - 300000);
        end
        ima = raw ? 31'($urandom()) : 31'($urandom_range(200000));
        imb = raw ? 31'($urandom()) : 31'($urandom_range(200000));
        if ($urandom_range(9) == 0) ima = 0;
        if ($urandom_range(9) == 0) imb = 0;
        send_body(pa, va, ima, 1'b0);
        send_body(pb, vb, imb, 1'b1);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (300) @(posedge clk);
    endtask

    task automatic write_rest(logic [CfgW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.rest = longint'(val);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] p [3], v [3], z [3];
        logic [CfgW-1:0] rests [4];
        rests = '{17'd0, 17'h1FFFF, 17'd32768, 17'd65536};
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        cfg_valid = 0;
        cfg_data = '0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        z = '{32'd0, 32'd0, 32'd0};
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: second before first, coincident, head-on, extremes
        p = '{32'd30000, 32'd0, 32'd0};
        v = '{32'hFFFF_0000, 32'd0, 32'd0};
        send_body(p, v, 31'h10000, 1'b1);
        send_body(z, z, 31'h10000, 1'b0);
        send_body(z, z, 31'h10000, 1'b1);
        v = '{32'h0001_0000, 32'd0, 32'd0};
        send_body(z, v, 31'h10000, 1'b0);
        send_body(p, z, 31'h10000, 1'b0);
        send_body(p, v, 31'h10000, 1'b1);
        send_body(z, z, 31'h10000, 1'b0);
        send_body(p, z, 31'd0, 1'b0);
        send_body(z, z, 31'd0, 1'b0);
        send_body(p, z, 31'd0, 1'b1);
        p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        send_body(p, v, 31'h7FFF_FFFF, 1'b0);
        p[0] = 32'h8000_1000;
        v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
        send_body(p, v, 31'h7FFF_FFFF, 1'b1);
        p = '{32'd65535, 32'd0, 32'd0};
        send_body(z, z, 31'd1, 1'b0);
        send_body(p, v, 31'd1, 1'b1);
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            write_rest(rests[ph]);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            if (ph == 2)
            begin
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int k = 0; k < 50; k++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    send_body(p, v, 31'($urandom()), 1'($urandom_range(1)));
                end
                else
                    send_pair($urandom_range(9) < 8, $urandom_range(9) < 2);
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("sphere_pair_impulse_resolve_unit verification clean");
        else
            $display("sphere_pair_impulse_resolve_unit verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/spir_pkg.sv
hdl/spir_mul.sv
hdl/spir_div.sv
hdl/spir_sqrt.sv
hdl/spir_datapath.sv
hdl/spir_ctrl.sv
hdl/sphere_pair_impulse_resolve_unit.sv
tb/tb.sv
